@@ src/bpa_pkg.sv @@
package bpa_pkg;

   localparam int WORD_BITS = 32;
   localparam int WORD_IDX  = 5;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_INIT  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

endpackage

@@ src/buddy_page_allocator.sv @@
// Buddy page allocator. Free blocks are kept as one bit per aligned block and
// order, packed into 32-bit words of a single-port memory that one
// read-modify-write sequencer walks. Every memory access presents the address,
// then uses the registered data, so the time a request takes is set by the
// number of words touched. Alloc: one access per word scanned from the
// requested order upwards, plus one per split level. Free: one access per word
// that the freed range covers at each order (overlap check), then one per
// merge level, ending with the access that marks the block free. Init: writes
// every word, 2^(clog2(ORDER_COUNT)+clog2(ceil(POOL_PAGES/32))) words, 512 at the
// defaults. Malformed requests answer on the next cycle. After reset the
// same pass clears the memory with busy high. busy is high while a request
// is in progress; each result appears for exactly one cycle with rsp_valid
// and cannot be held off, so the receiver must take it then. A new request
// may be started in the cycle that shows the previous result.
module buddy_page_allocator #(
   parameter int POOL_PAGES  = 1024,
   parameter int ORDER_COUNT = 11,
   localparam int PW = $clog2(POOL_PAGES),
   localparam int CW = PW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [1:0]    req_func,
   input  logic [CW-1:0] req_request_pages,
   input  logic [PW-1:0] req_page_index,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic [PW-1:0] rsp_block_base,
   output logic [CW-1:0] rsp_block_pages,
   output logic [CW-1:0] rsp_free_total,
   input  logic          csr_wr_en,
   input  logic [CW-1:0] csr_wr_data
);

   localparam int WB     = bpa_pkg::WORD_BITS;
   localparam int WI     = bpa_pkg::WORD_IDX;
   localparam int OW     = $clog2(ORDER_COUNT);
   localparam int OB     = $clog2(ORDER_COUNT + 1);
   localparam int WORDS  = (POOL_PAGES + WB - 1) / WB;
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int ADDR_W = OW + AW;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int XW     = PW + 6;
   localparam int TOP    = ORDER_COUNT - 1;

   localparam logic [3:0] IDLE    = 4'd0;
   localparam logic [3:0] CLR     = 4'd1;
   localparam logic [3:0] A_FET   = 4'd2;
   localparam logic [3:0] A_SCAN  = 4'd3;
   localparam logic [3:0] S_FET   = 4'd4;
   localparam logic [3:0] S_SPLIT = 4'd5;
   localparam logic [3:0] F_FET   = 4'd6;
   localparam logic [3:0] F_CHK   = 4'd7;
   localparam logic [3:0] M_FET   = 4'd8;
   localparam logic [3:0] M_STEP  = 4'd9;
   localparam logic [3:0] P_FET   = 4'd10;
   localparam logic [3:0] P_SET   = 4'd11;

   function automatic logic [OB-1:0] order_of(input logic [CW-1:0] n);
      logic [OB-1:0] r;
      r = OB'(ORDER_COUNT);
      for (int o = ORDER_COUNT - 1; o >= 0; o--) begin
         if (32'(n) <= (32'd1 << o)) r = OB'(o);
      end
      return r;
   endfunction

   function automatic logic [WI-1:0] lowest_set(input bpa_pkg::word_type w);
      logic [WI-1:0] r;
      r = '0;
      for (int j = WB - 1; j >= 0; j--) begin
         if (w[j]) r = WI'(j);
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] word_of(input logic [PW-1:0] b);
      logic [XW-1:0] t;
      t = XW'(b) >> WI;
      return t[AW-1:0];
   endfunction

   function automatic logic [WI-1:0] bit_of(input logic [PW-1:0] b);
      logic [XW-1:0] t;
      t = XW'(b);
      return t[WI-1:0];
   endfunction

   function automatic bpa_pkg::word_type one_at(input logic [WI-1:0] j);
      return bpa_pkg::word_type'(1) << j;
   endfunction

   // stop merging at the top order or where the buddy lies outside the pool
   function automatic logic merge_stop(input logic [OW-1:0] o, input logic [PW-1:0] b);
      return (32'(o) >= TOP) || ((32'(b) ^ 32'd1) >= (32'(POOL_PAGES) >> o));
   endfunction

   // word of the freshly carved pool: top order holds pc>>TOP blocks from 0,
   // every lower order o holds one block right after the larger ones if pc[o]
   function automatic bpa_pkg::word_type init_word(input logic [ADDR_W-1:0] a,
                                                   input logic [CW-1:0] pc);
      logic [OW-1:0]      o;
      logic [AW-1:0]      w;
      logic [XW-1:0]      pos;
      logic [XW-1:0]      tgt;
      logic [XW-1:0]      cnt;
      logic [XW-1:0]      has;
      bpa_pkg::word_type  r;
      o   = a[ADDR_W-1 -: OW];
      w   = a[AW-1:0];
      cnt = XW'(pc) >> TOP;
      has = (XW'(pc) >> o) & XW'(1);
      tgt = (XW'(pc) >> (32'(o) + 1)) << 1;
      r   = '0;
      for (int j = 0; j < WB; j++) begin
         pos = (XW'(w) << WI) | XW'(j);
         if (32'(o) == TOP) r[j] = pos < cnt;
         else if (32'(o) < TOP) r[j] = (has != '0) && (pos == tgt);
      end
      return r;
   endfunction

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     csr_pc_ff;
   logic [CW-1:0]     sweep_pc_ff, sweep_pc_in;
   logic              report_ff, report_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [OW-1:0]     ord_ff, ord_in;
   logic [OW-1:0]     cur_ord_ff, cur_ord_in;
   logic [AW-1:0]     word_ff, word_in;
   logic [PW-1:0]     blk_ff, blk_in;
   logic [PW-1:0]     idx_ff, idx_in;
   logic [PW-1:0]     last_ff, last_in;
   logic [CW-1:0]     free_total_ff, free_total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [PW-1:0]     rsp_base_ff, rsp_base_in;
   logic [CW-1:0]     rsp_pages_ff, rsp_pages_in;
   logic [CW-1:0]     rsp_total_ff, rsp_total_in;

   bpa_pkg::word_type mem [DEPTH];
   bpa_pkg::word_type rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   bpa_pkg::word_type mem_wdata;

   logic [OB-1:0]     ordc;
   logic              size_ok;
   logic [XW-1:0]     req_sz;
   logic [XW-1:0]     req_end;
   logic              free_ok;
   logic [XW-1:0]     lo, hi;
   logic [XW-1:0]     whi_x, wlo_next_x;
   bpa_pkg::word_type range_mask;
   logic [XW-1:0]     pos;
   logic [WI-1:0]     low_bit;
   logic [XW-1:0]     found_x;
   logic [PW-1:0]     found_b;
   logic [PW-1:0]     nb;
   logic [OW-1:0]     no;
   logic [PW-1:0]     bud;
   logic [CW-1:0]     ord_pages;

   assign busy            = (state_ff != IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_base  = rsp_base_ff;
   assign rsp_block_pages = rsp_pages_ff;
   assign rsp_free_total  = rsp_total_ff;

   assign mem_addr = (state_ff == CLR) ? clr_ff : {cur_ord_ff, word_ff};

   always_comb begin
      ordc    = order_of(req_request_pages);
      size_ok = (32'(ordc) < ORDER_COUNT) && ((32'd1 << ordc) <= POOL_PAGES);
      req_sz  = XW'(1) << ordc;
      req_end = XW'(req_page_index) + req_sz;
      free_ok = size_ok && ((XW'(req_page_index) & (req_sz - XW'(1))) == '0) &&
                (req_end <= XW'(POOL_PAGES));

      lo         = XW'(idx_ff) >> cur_ord_ff;
      hi         = XW'(last_ff) >> cur_ord_ff;
      whi_x      = hi >> WI;
      wlo_next_x = (XW'(idx_ff) >> (32'(cur_ord_ff) + 1)) >> WI;
      for (int j = 0; j < WB; j++) begin
         pos           = (XW'(word_ff) << WI) | XW'(j);
         range_mask[j] = (pos >= lo) && (pos <= hi);
      end

      low_bit   = lowest_set(rd_ff);
      found_x   = (XW'(word_ff) << WI) | XW'(low_bit);
      found_b   = found_x[PW-1:0];
      bud       = blk_ff ^ PW'(1);
      nb        = blk_ff >> 1;
      no        = cur_ord_ff + OW'(1);
      ord_pages = CW'(1) << ord_ff;
   end

   always_comb begin
      state_in      = state_ff;
      sweep_pc_in   = sweep_pc_ff;
      report_in     = report_ff;
      clr_in        = clr_ff;
      ord_in        = ord_ff;
      cur_ord_in    = cur_ord_ff;
      word_in       = word_ff;
      blk_in        = blk_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      free_total_in = free_total_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = '0;
      rsp_pages_in  = '0;
      mem_we        = 1'b0;
      mem_wdata     = rd_ff;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               rsp_status_in = bpa_pkg::ST_BAD;
               unique case (req_func)
                  bpa_pkg::FUNC_INIT: begin
                     if (32'(csr_pc_ff) <= POOL_PAGES) begin
                        sweep_pc_in = csr_pc_ff;
                        report_in   = 1'b1;
                        clr_in      = '0;
                        state_in    = CLR;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  bpa_pkg::FUNC_ALLOC: begin
                     if (size_ok) begin
                        ord_in     = ordc[OW-1:0];
                        cur_ord_in = ordc[OW-1:0];
                        word_in    = '0;
                        state_in   = A_FET;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  bpa_pkg::FUNC_FREE: begin
                     if (free_ok) begin
                        ord_in     = ordc[OW-1:0];
                        idx_in     = req_page_index;
                        last_in    = PW'(req_end - XW'(1));
                        cur_ord_in = '0;
                        word_in    = word_of(req_page_index);
                        state_in   = F_FET;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end

         CLR: begin
            mem_we    = 1'b1;
            mem_wdata = init_word(clr_ff, sweep_pc_ff);
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = IDLE;
               if (report_ff) begin
                  free_total_in = sweep_pc_ff;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bpa_pkg::ST_OK;
               end
               report_in = 1'b0;
            end
         end

         A_FET: state_in = A_SCAN;

         A_SCAN: begin
            if (rd_ff != '0) begin
               mem_we    = 1'b1;
               mem_wdata = rd_ff & ~one_at(low_bit);
               if (cur_ord_ff == ord_ff) begin
                  free_total_in = free_total_ff - ord_pages;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bpa_pkg::ST_OK;
                  rsp_base_in   = found_b << ord_ff;
                  rsp_pages_in  = ord_pages;
                  state_in      = IDLE;
               end else begin
                  blk_in     = found_b << 1;
                  word_in    = word_of(found_b << 1);
                  cur_ord_in = cur_ord_ff - OW'(1);
                  state_in   = S_FET;
               end
            end else if (word_ff != AW'(WORDS - 1)) begin
               word_in  = word_ff + AW'(1);
               state_in = A_FET;
            end else if (32'(cur_ord_ff) != TOP) begin
               cur_ord_in = no;
               word_in    = '0;
               state_in   = A_FET;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bpa_pkg::ST_NOSPACE;
               state_in      = IDLE;
            end
         end

         S_FET: state_in = S_SPLIT;

         // free the right half, descend with the left one
         S_SPLIT: begin
            mem_we    = 1'b1;
            mem_wdata = rd_ff | one_at(bit_of(blk_ff | PW'(1)));
            if (cur_ord_ff == ord_ff) begin
               free_total_in = free_total_ff - ord_pages;
               rsp_valid_in  = 1'b1;
               rsp_status_in = bpa_pkg::ST_OK;
               rsp_base_in   = blk_ff << ord_ff;
               rsp_pages_in  = ord_pages;
               state_in      = IDLE;
            end else begin
               blk_in     = blk_ff << 1;
               word_in    = word_of(blk_ff << 1);
               cur_ord_in = cur_ord_ff - OW'(1);
               state_in   = S_FET;
            end
         end

         F_FET: state_in = F_CHK;

         // any free bit inside the freed range at any order means overlap
         F_CHK: begin
            if ((rd_ff & range_mask) != '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bpa_pkg::ST_BAD;
               state_in      = IDLE;
            end else if (XW'(word_ff) != whi_x) begin
               word_in  = word_ff + AW'(1);
               state_in = F_FET;
            end else if (32'(cur_ord_ff) != TOP) begin
               cur_ord_in = no;
               word_in    = wlo_next_x[AW-1:0];
               state_in   = F_FET;
            end else begin
               cur_ord_in = ord_ff;
               blk_in     = idx_ff >> ord_ff;
               word_in    = word_of(idx_ff >> ord_ff);
               state_in   = merge_stop(ord_ff, idx_ff >> ord_ff) ? P_FET : M_FET;
            end
         end

         M_FET: state_in = M_STEP;

         M_STEP: begin
            mem_we = 1'b1;
            if (rd_ff[bit_of(bud)] == 1'b0) begin
               mem_wdata     = rd_ff | one_at(bit_of(blk_ff));
               free_total_in = free_total_ff + ord_pages;
               rsp_valid_in  = 1'b1;
               rsp_status_in = bpa_pkg::ST_OK;
               rsp_pages_in  = ord_pages;
               state_in      = IDLE;
            end else begin
               mem_wdata  = rd_ff & ~one_at(bit_of(bud));
               blk_in     = nb;
               word_in    = word_of(nb);
               cur_ord_in = no;
               state_in   = merge_stop(no, nb) ? P_FET : M_FET;
            end
         end

         P_FET: state_in = P_SET;

         P_SET: begin
            mem_we        = 1'b1;
            mem_wdata     = rd_ff | one_at(bit_of(blk_ff));
            free_total_in = free_total_ff + ord_pages;
            rsp_valid_in  = 1'b1;
            rsp_status_in = bpa_pkg::ST_OK;
            rsp_pages_in  = ord_pages;
            state_in      = IDLE;
         end

         default: state_in = IDLE;
      endcase

      rsp_total_in = free_total_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CLR;
         sweep_pc_ff   <= '0;
         report_ff     <= 1'b0;
         clr_ff        <= '0;
         free_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         csr_pc_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_pc_ff   <= sweep_pc_in;
         report_ff     <= report_in;
         clr_ff        <= clr_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) csr_pc_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff        <= ord_in;
      cur_ord_ff    <= cur_ord_in;
      word_ff       <= word_in;
      blk_ff        <= blk_in;
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_total_ff  <= rsp_total_in;
   end

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(free_total_ff) <= POOL_PAGES)
      else $error("free page total beyond pool");

   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("request neither in progress nor answered");

   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bpa_pkg::ST_OK) |->
         (rsp_block_base == '0 && rsp_block_pages == '0))
      else $error("failed request reports a block");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == A_SCAN || state_ff == S_SPLIT) |-> (cur_ord_ff >= ord_ff))
      else $error("alloc walked below the requested order");

endmodule
